/* hw/rtl/csm_pkg.sv */
// ============================================================================
// csm_pkg: shared types and constants of the clock set menu controller
// Holds the record layout, the command and mode codes, the joystick windows
// and the queue geometry that the front, the queue and the back all use.
// ============================================================================
package csm_pkg;

    // Item kind codes on the input channel.
    localparam logic [1:0] KIND_JOY   = 2'd0;
    localparam logic [1:0] KIND_RTC   = 2'd1;
    localparam logic [1:0] KIND_ALARM = 2'd2;

    // Joystick windows, bounds exclusive.
    localparam logic [9:0] UP_LO    = 10'd180;
    localparam logic [9:0] UP_HI    = 10'd185;
    localparam logic [9:0] LEFT_LO  = 10'd315;
    localparam logic [9:0] LEFT_HI  = 10'd325;
    localparam logic [9:0] DOWN_LO  = 10'd460;
    localparam logic [9:0] DOWN_HI  = 10'd470;
    localparam logic [9:0] RIGHT_LO = 10'd614;
    localparam logic [9:0] RIGHT_HI = 10'd624;
    localparam logic [9:0] ENTER_LO = 10'd770;
    localparam logic [9:0] ENTER_HI = 10'd800;

    // Field wrap moduli and offsets.
    localparam logic [12:0] MOD_HOURS  = 13'd24;
    localparam logic [12:0] MOD_MINSEC = 13'd60;
    localparam logic [12:0] MOD_DAY    = 13'd31;
    localparam logic [12:0] MOD_MONTH  = 13'd12;
    localparam logic [12:0] MOD_YEAR   = 13'd4000;
    localparam logic [12:0] DAY_BACK   = 13'd29;
    localparam logic [12:0] MONTH_BACK = 13'b1010;

    // Cursor positions.
    localparam logic [2:0] CUR_HOURS   = 3'd0;
    localparam logic [2:0] CUR_MINUTES = 3'd1;
    localparam logic [2:0] CUR_SECONDS = 3'd2;
    localparam logic [2:0] CUR_DAY     = 3'd3;
    localparam logic [2:0] CUR_MONTH   = 3'd4;
    localparam logic [2:0] CUR_YEAR    = 3'd5;
    localparam logic [2:0] CUR_SAVE    = 3'd6;
    localparam logic [3:0] CUR_COUNT   = 4'd7;

    // Command queue geometry.
    localparam logic [1:0] Q_FULL = 2'd2;

    typedef enum logic [1:0] {
        MODE_VIEW  = 2'd0,
        MODE_ALARM = 2'd1,
        MODE_TIME  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ALARM = 2'd1,
        WR_TIME  = 2'd2
    } t_wr;

    typedef enum logic [2:0] {
        CMD_NOP   = 3'd0,
        CMD_UP    = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_DOWN  = 3'd3,
        CMD_RIGHT = 3'd4,
        CMD_ENTER = 3'd5,
        CMD_RTC   = 3'd6,
        CMD_ALARM = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_rec;

    typedef struct packed {
        t_cmd cmd;
        t_rec rtc;
    } t_q_entry;

    typedef struct packed {
        t_mode      mode;
        logic [2:0] cursor;
        t_rec       shown;
        logic       save_flag;
        t_wr        write_target;
        logic       buzzer_on;
    } t_result;

endpackage

/* hw/rtl/csm_if.sv */
// ============================================================================
// csm_if: channel interfaces of the clock set menu controller
// A transfer happens at a rising clock edge with valid and ready both high.
// ============================================================================
interface csm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  adc_sample;
    logic [4:0]  rtc_hours;
    logic [5:0]  rtc_minutes;
    logic [5:0]  rtc_seconds;
    logic [4:0]  rtc_day;
    logic [3:0]  rtc_month;
    logic [11:0] rtc_year;

    modport source (
        output valid, kind, adc_sample, rtc_hours, rtc_minutes, rtc_seconds,
               rtc_day, rtc_month, rtc_year,
        input  ready
    );
    modport sink (
        input  valid, kind, adc_sample, rtc_hours, rtc_minutes, rtc_seconds,
               rtc_day, rtc_month, rtc_year,
        output ready
    );
endinterface

interface csm_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  cursor;
    logic [4:0]  show_hours;
    logic [5:0]  show_minutes;
    logic [5:0]  show_seconds;
    logic [4:0]  show_day;
    logic [3:0]  show_month;
    logic [11:0] show_year;
    logic        save_flag;
    logic [1:0]  write_target;
    logic        buzzer_on;

    modport source (
        output valid, mode, cursor, show_hours, show_minutes, show_seconds,
               show_day, show_month, show_year, save_flag, write_target,
               buzzer_on,
        input  ready
    );
    modport sink (
        input  valid, mode, cursor, show_hours, show_minutes, show_seconds,
               show_day, show_month, show_year, save_flag, write_target,
               buzzer_on,
        output ready
    );
endinterface

/* hw/rtl/csm_front.sv */
// ============================================================================
// csm_front: input side of the clock set menu controller
// Accepts items and sorts each one into a menu command for the queue.
// ============================================================================
module csm_front
    import csm_pkg::*;
(
    csm_item_if.sink i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    function automatic t_cmd classify(input logic [9:0] v);
        t_cmd c;
        c = CMD_NOP;
        if (v > UP_LO && v < UP_HI) begin
            c = CMD_UP;
        end else if (v > LEFT_LO && v < LEFT_HI) begin
            c = CMD_LEFT;
        end else if (v > DOWN_LO && v < DOWN_HI) begin
            c = CMD_DOWN;
        end else if (v > RIGHT_LO && v < RIGHT_HI) begin
            c = CMD_RIGHT;
        end else if (v > ENTER_LO && v < ENTER_HI) begin
            c = CMD_ENTER;
        end
        return c;
    endfunction

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_entry.rtc.hours   = i_item.rtc_hours;
        o_entry.rtc.minutes = i_item.rtc_minutes;
        o_entry.rtc.seconds = i_item.rtc_seconds;
        o_entry.rtc.day     = i_item.rtc_day;
        o_entry.rtc.month   = i_item.rtc_month;
        o_entry.rtc.year    = i_item.rtc_year;
        case (i_item.kind)
            KIND_JOY:   o_entry.cmd = classify(i_item.adc_sample);
            KIND_RTC:   o_entry.cmd = CMD_RTC;
            KIND_ALARM: o_entry.cmd = CMD_ALARM;
            default:    o_entry.cmd = CMD_NOP;
        endcase
    end

endmodule

/* hw/rtl/csm_queue.sv */
// ============================================================================
// csm_queue: two-entry command queue
// Decouples the classifying front from the executing back.
// ============================================================================
module csm_queue
    import csm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_q_entry o_entry
);

    t_q_entry   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == Q_FULL);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != Q_FULL))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("queue read while empty");

endmodule

/* hw/rtl/csm_back.sv */
// ============================================================================
// csm_back: menu state and result register
// Runs one queued command per cycle unless a result waits; registers results.
// ============================================================================
module csm_back
    import csm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  t_q_entry       i_entry,
    output logic           o_pop,
    csm_result_if.source   o_result
);

    // Reduces x modulo m for x below three times m.
    function automatic logic [12:0] wrap_mod(input logic [12:0] x, input logic [12:0] m);
        logic [12:0] r;
        if (x >= (m << 1)) begin
            r = x - (m << 1);
        end else if (x >= m) begin
            r = x - m;
        end else begin
            r = x;
        end
        return r;
    endfunction

    t_mode      r_mode,    n_mode;
    logic [2:0] r_cursor,  n_cursor;
    logic       r_save,    n_save;
    logic       r_buzzer,  n_buzzer;
    t_rec       r_current, n_current;
    t_rec       r_stored,  n_stored;
    t_rec       r_ed_alarm, n_ed_alarm;
    t_rec       r_ed_time,  n_ed_time;
    t_wr        w_target;
    t_rec       w_shown;
    t_rec       w_adj;
    logic       w_toggle;
    logic [2:0] w_move;
    logic       w_edit;
    logic       r_valid;
    t_result    r_out;

    assign o_pop  = i_q_valid && (!r_valid || o_result.ready);
    assign w_edit = (r_mode == MODE_ALARM) || (r_mode == MODE_TIME);

    // Up or down applied to the record under edit; on save it toggles the flag.
    always_comb begin
        t_rec        src;
        logic        up;
        logic [12:0] v;
        src      = (r_mode == MODE_ALARM) ? r_ed_alarm : r_ed_time;
        up       = (i_entry.cmd == CMD_UP);
        w_adj    = src;
        w_toggle = 1'b0;
        v        = '0;
        case (r_cursor)
            CUR_HOURS: begin
                v = wrap_mod({8'd0, src.hours} + (up ? 13'd1 : MOD_HOURS - 13'd1),
                             MOD_HOURS);
                w_adj.hours = v[4:0];
            end
            CUR_MINUTES: begin
                v = wrap_mod({7'd0, src.minutes} + (up ? 13'd1 : MOD_MINSEC - 13'd1),
                             MOD_MINSEC);
                w_adj.minutes = v[5:0];
            end
            CUR_SECONDS: begin
                v = wrap_mod({7'd0, src.seconds} + (up ? 13'd1 : MOD_MINSEC - 13'd1),
                             MOD_MINSEC);
                w_adj.seconds = v[5:0];
            end
            CUR_DAY: begin
                v = wrap_mod({8'd0, src.day} + (up ? 13'd0 : DAY_BACK), MOD_DAY) + 13'd1;
                w_adj.day = v[4:0];
            end
            CUR_MONTH: begin
                v = wrap_mod({9'd0, src.month} + (up ? 13'd0 : MONTH_BACK), MOD_MONTH)
                    + 13'd1;
                w_adj.month = v[3:0];
            end
            CUR_YEAR: begin
                v = wrap_mod({1'b0, src.year} + (up ? 13'd1 : MOD_YEAR - 13'd1),
                             MOD_YEAR);
                w_adj.year = v[11:0];
            end
            default: w_toggle = 1'b1;
        endcase
    end

    // Cursor step; the alarm editor skips the date fields.
    always_comb begin
        logic [3:0] s;
        logic       alarm;
        alarm = (r_mode == MODE_ALARM);
        if (i_entry.cmd == CMD_RIGHT) begin
            s = {1'b0, r_cursor} + 4'd1;
        end else begin
            s = {1'b0, r_cursor} + CUR_COUNT - 4'd1;
        end
        if (s >= CUR_COUNT) begin
            s = s - CUR_COUNT;
        end
        w_move = s[2:0];
        if (alarm && i_entry.cmd == CMD_RIGHT && w_move == CUR_DAY) begin
            w_move = CUR_SAVE;
        end else if (alarm && i_entry.cmd == CMD_LEFT && w_move == CUR_YEAR) begin
            w_move = CUR_SECONDS;
        end
    end

    // Next menu mode.
    always_comb begin
        n_mode = r_mode;
        if (o_pop && i_entry.cmd == CMD_ENTER) begin
            case (r_mode)
                MODE_ALARM: n_mode = MODE_TIME;
                MODE_TIME:  n_mode = MODE_VIEW;
                default:    n_mode = MODE_ALARM;
            endcase
        end
    end

    // Everything else the command changes.
    always_comb begin
        n_cursor   = r_cursor;
        n_save     = r_save;
        n_buzzer   = r_buzzer;
        n_current  = r_current;
        n_stored   = r_stored;
        n_ed_alarm = r_ed_alarm;
        n_ed_time  = r_ed_time;
        w_target   = WR_NONE;
        if (o_pop) begin
            case (i_entry.cmd)
                CMD_UP, CMD_DOWN, CMD_LEFT, CMD_RIGHT: begin
                    if (!w_edit) begin
                        n_buzzer = 1'b0;
                    end else if (i_entry.cmd == CMD_LEFT || i_entry.cmd == CMD_RIGHT) begin
                        n_cursor = w_move;
                    end else if (w_toggle) begin
                        n_save = ~r_save;
                    end else if (r_mode == MODE_ALARM) begin
                        n_ed_alarm = w_adj;
                    end else begin
                        n_ed_time = w_adj;
                    end
                end
                CMD_ENTER: begin
                    case (r_mode)
                        MODE_ALARM: begin
                            if (r_save) begin
                                n_stored = r_ed_alarm;
                                w_target = WR_ALARM;
                            end
                            n_ed_time = r_current;
                            n_cursor  = CUR_HOURS;
                            n_save    = 1'b0;
                        end
                        MODE_TIME: begin
                            if (r_save) begin
                                n_current = r_ed_time;
                                w_target  = WR_TIME;
                            end
                            n_save = 1'b0;
                        end
                        default: begin
                            n_ed_alarm = r_stored;
                            n_cursor   = CUR_HOURS;
                        end
                    endcase
                end
                CMD_RTC:   n_current = i_entry.rtc;
                CMD_ALARM: n_buzzer  = 1'b1;
                default: ;
            endcase
        end
    end

    // Record reported with the result.
    always_comb begin
        case (w_target)
            WR_ALARM: w_shown = n_stored;
            WR_TIME:  w_shown = n_current;
            default: begin
                case (n_mode)
                    MODE_ALARM: w_shown = n_ed_alarm;
                    MODE_TIME:  w_shown = n_ed_time;
                    default:    w_shown = n_current;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_VIEW;
            r_cursor   <= CUR_HOURS;
            r_save     <= 1'b0;
            r_buzzer   <= 1'b0;
            r_current  <= '0;
            r_stored   <= '0;
            r_ed_alarm <= '0;
            r_ed_time  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_cursor   <= n_cursor;
            r_save     <= n_save;
            r_buzzer   <= n_buzzer;
            r_current  <= n_current;
            r_stored   <= n_stored;
            r_ed_alarm <= n_ed_alarm;
            r_ed_time  <= n_ed_time;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.mode         <= n_mode;
            r_out.cursor       <= n_cursor;
            r_out.shown        <= w_shown;
            r_out.save_flag    <= n_save;
            r_out.write_target <= w_target;
            r_out.buzzer_on    <= n_buzzer;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.mode         = r_out.mode;
    assign o_result.cursor       = r_out.cursor;
    assign o_result.show_hours   = r_out.shown.hours;
    assign o_result.show_minutes = r_out.shown.minutes;
    assign o_result.show_seconds = r_out.shown.seconds;
    assign o_result.show_day     = r_out.shown.day;
    assign o_result.show_month   = r_out.shown.month;
    assign o_result.show_year    = r_out.shown.year;
    assign o_result.save_flag    = r_out.save_flag;
    assign o_result.write_target = r_out.write_target;
    assign o_result.buzzer_on    = r_out.buzzer_on;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("executed command left no result");

    a_alarm_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ALARM) |->
            !(r_cursor == CUR_DAY || r_cursor == CUR_MONTH || r_cursor == CUR_YEAR))
        else $error("alarm editor cursor on a date field");

    a_write_clears_save: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.write_target != WR_NONE) |-> !r_out.save_flag)
        else $error("save flag still set after a write");

endmodule

/* hw/rtl/clock_set_menu_controller.sv */
// ============================================================================
// clock_set_menu_controller: joystick driven clock and alarm setting menu
// Top level: front classifier, command queue and menu state back end.
// ============================================================================
// Each input transfer is a joystick ADC sample, an RTC time update or an
// alarm match, and each one yields exactly one result transfer carrying the
// menu mode, cursor, save flag, buzzer level, the write strobe target and the
// record to display. The block takes one item per clock while the result
// side is not stalled: the front sorts the item into a command in the cycle
// it is accepted and writes it into a two-entry queue, and the back end
// executes one command per clock while its result register is free or being
// taken, and loads the result register. With items arriving every clock the
// queue holds one command in steady flow; its second entry takes one more
// item while a finished result waits, so any cycle without a result transfer
// fills the queue and i_item.ready drops in the following cycle. Ready stays
// low for as long as the result side stalls and comes back in the cycle after
// the waiting result is taken. There are no configuration registers and no
// clearing pass; all menu state resets to view mode with all records zero.
module clock_set_menu_controller
    import csm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    csm_item_if.sink     i_item,
    csm_result_if.source o_result
);

    // Handshake between the front and the command queue.
    logic     w_push;
    logic     w_full;
    t_q_entry w_push_entry;

    // Handshake between the command queue and the back end.
    logic     w_q_valid;
    logic     w_pop;
    t_q_entry w_q_entry;

    // The front is purely combinational: it only classifies the transfer
    // and pushes it when the queue has room.
    csm_front u_front (
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // The queue decouples the input handshake from the result handshake.
    csm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // The back end owns all menu state and the result register.
    csm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_entry   (w_q_entry),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

endmodule
